/* rtl/core/rbw_pkg.sv */
// rbw_pkg: shared word types and field widths for the ROM block window.
// No dependencies; imported by rom_block_window_lru.
package rbw_pkg;

  localparam int unsigned OffW    = 26;
  localparam int unsigned XLenW   = 21;
  localparam int unsigned SizeW   = 27;
  localparam int unsigned WAddrW  = 20;
  localparam int unsigned SegLenW = 17;
  localparam int unsigned EvBlkW  = 10;
  localparam int unsigned CountW  = 32;

  localparam logic [XLenW-1:0] XferCap = XLenW'(1048576);

  localparam logic FuncLookup = 1'b0;
  localparam logic FuncXfer   = 1'b1;

  typedef struct packed {
    logic             func;
    logic [OffW-1:0]  byte_offset;
    logic [XLenW-1:0] xfer_length;
  } req_t;

  typedef struct packed {
    logic [WAddrW-1:0]  window_addr;
    logic [SegLenW-1:0] seg_length;
    logic               found;
    logic               paged_in;
    logic [EvBlkW-1:0]  evicted_block;
    logic [CountW-1:0]  page_in_total;
    logic               last_segment;
  } rsp_t;

endpackage

/* rtl/core/rom_block_window_lru.sv */
// ROM block window with LRU replacement. Frame table {block, rank} in a sync RAM.
// Streaming segment: setup, a scan of the frame table, a rank update pass over it, then
// the result state; the RAM port serves one entry per cycle. Later segments of a transfer
// skip setup. Lookup hits skip the update. Non-streaming: setup, then the result state
// emits each segment word. Reset: table filled, frame i holding block i at rank i.
// Results appear for one cycle on result_valid_o; the receiver cannot stall.
module rom_block_window_lru #(
  parameter int unsigned BLOCK_BYTES   = 65536,
  parameter int unsigned MAX_BLOCKS    = 1024,
  parameter int unsigned WINDOW_FRAMES = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rbw_pkg::SizeW-1:0] cfg_wdata_i,
  input  logic                     start,
  output logic                     busy,
  input  rbw_pkg::req_t            req_i,
  output logic                     result_valid_o,
  output rbw_pkg::rsp_t            result_o
);
  import rbw_pkg::*;

  localparam int unsigned OB = $clog2(BLOCK_BYTES);
  localparam int unsigned BW = $clog2(MAX_BLOCKS);
  localparam int unsigned FW = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
  localparam int unsigned CW = FW + 1;
  localparam int unsigned EW = BW + FW;
  localparam longint unsigned CapBytes = longint'(MAX_BLOCKS) * longint'(BLOCK_BYTES);
  localparam longint unsigned WinBytes = longint'(WINDOW_FRAMES) * longint'(BLOCK_BYTES);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PREP  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_UPD   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [SizeW-1:0] rom_size_q;
  logic [SizeW-1:0] eff;
  logic streaming;

  logic             func_q;
  logic [SizeW-1:0] cur_off_q, cur_off_d;
  logic [XLenW-1:0] rem_q, rem_d;
  logic             nf_q, nf_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CountW-1:0] pic_q;

  logic             hit_q, hit_d;
  logic [FW-1:0]    hit_idx_q, hit_idx_d;
  logic [FW-1:0]    hit_rank_q, hit_rank_d;
  logic [FW-1:0]    vic_idx_q, vic_idx_d;
  logic [FW-1:0]    vic_rank_q, vic_rank_d;
  logic [BW-1:0]    vic_blk_q, vic_blk_d;
  logic [FW-1:0]    tgt_q, tgt_d;
  logic [FW-1:0]    tgt_rank_q, tgt_rank_d;
  logic             miss_q, miss_d;

  logic [EW-1:0] mem [WINDOW_FRAMES];
  logic [EW-1:0] rd_q;
  logic [FW-1:0] rd_addr;
  logic          mem_we;
  logic [FW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [FW-1:0] pidx;
  logic [BW-1:0] e_blk;
  logic [FW-1:0] e_rank;
  logic [BW-1:0] blk;
  logic [OB-1:0] inb;
  logic [XLenW-1:0] room, chunk;
  logic [SizeW:0] end_sum;

  logic          res_v_q;
  rsp_t          res_q, res_d;
  logic [CountW-1:0] pic_d;
  logic [63:0]   addr_full;

  // effective ROM size and mode
  always_comb begin
    eff = rom_size_q;
    if (64'(rom_size_q) > CapBytes) begin
      eff = CapBytes[SizeW-1:0];
    end
    streaming = 64'(eff) > WinBytes;
  end

  assign busy = (state_q != S_IDLE);
  assign pidx = FW'(cnt_q - CW'(1));
  assign e_blk = rd_q[EW-1:FW];
  assign e_rank = rd_q[FW-1:0];
  assign blk = BW'(cur_off_q >> OB);
  assign inb = cur_off_q[OB-1:0];
  assign room = XLenW'(BLOCK_BYTES) - XLenW'(inb);
  assign chunk = (room > rem_q) ? rem_q : room;
  assign end_sum = (SizeW+1)'(cur_off_q) + (SizeW+1)'(rem_q);
  assign rd_addr = cnt_q[FW-1:0];

  always_comb begin
    state_d = state_q;
    cur_off_d = cur_off_q;
    rem_d = rem_q;
    nf_d = nf_q;
    cnt_d = cnt_q;
    hit_d = hit_q;
    hit_idx_d = hit_idx_q;
    hit_rank_d = hit_rank_q;
    vic_idx_d = vic_idx_q;
    vic_rank_d = vic_rank_q;
    vic_blk_d = vic_blk_q;
    tgt_d = tgt_q;
    tgt_rank_d = tgt_rank_q;
    miss_d = miss_q;
    mem_we = 1'b0;
    wr_addr = pidx;
    wr_data = rd_q;
    pic_d = pic_q;
    res_d = res_q;
    addr_full = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        wr_addr = cnt_q[FW-1:0];
        wr_data = {BW'(cnt_q[FW-1:0]), cnt_q[FW-1:0]};
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(WINDOW_FRAMES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        nf_d = 1'b0;
        cnt_d = '0;
        state_d = streaming ? S_SCAN : S_EMIT;
        if (eff == '0) begin
          nf_d = 1'b1;
          state_d = S_EMIT;
        end else if (func_q == FuncLookup) begin
          rem_d = '0;
          if (cur_off_q >= eff) begin
            cur_off_d = eff - SizeW'(1);
          end
        end else if (cur_off_q >= eff || rem_q == '0) begin
          nf_d = 1'b1;
          state_d = S_EMIT;
        end else if (end_sum > (SizeW+1)'(eff)) begin
          rem_d = XLenW'(eff - cur_off_q);
        end
      end
      S_SCAN: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0) begin
          if (cnt_q == CW'(1)) begin
            hit_d = 1'b0;
            vic_idx_d = '0;
            vic_rank_d = e_rank;
            vic_blk_d = e_blk;
          end else if (e_rank > vic_rank_q) begin
            vic_idx_d = pidx;
            vic_rank_d = e_rank;
            vic_blk_d = e_blk;
          end
          if (e_blk == blk && !(cnt_q != CW'(1) && hit_q)) begin
            hit_d = 1'b1;
            hit_idx_d = pidx;
            hit_rank_d = e_rank;
          end
          if (cnt_q == CW'(WINDOW_FRAMES)) begin
            cnt_d = '0;
            miss_d = !hit_d;
            tgt_d = hit_d ? hit_idx_d : vic_idx_d;
            tgt_rank_d = hit_d ? hit_rank_d : vic_rank_d;
            state_d = (hit_d && func_q == FuncLookup) ? S_EMIT : S_UPD;
          end
        end
      end
      S_UPD: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q != '0) begin
          mem_we = 1'b1;
          if (pidx == tgt_q) begin
            wr_data = {blk, FW'(0)};
          end else if (e_rank < tgt_rank_q) begin
            wr_data = {e_blk, e_rank + FW'(1)};
          end
          if (cnt_q == CW'(WINDOW_FRAMES)) begin
            cnt_d = '0;
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        res_d = '0;
        res_d.page_in_total = pic_q;
        res_d.last_segment = 1'b1;
        state_d = S_IDLE;
        if (!nf_q) begin
          res_d.found = 1'b1;
          if (streaming) begin
            addr_full = (64'(tgt_q) << OB) | 64'(inb);
            res_d.window_addr = addr_full[WAddrW-1:0];
            if (miss_q) begin
              pic_d = pic_q + CountW'(1);
              res_d.paged_in = 1'b1;
              res_d.evicted_block = EvBlkW'(vic_blk_q);
              res_d.page_in_total = pic_d;
            end
          end else begin
            res_d.window_addr = cur_off_q[WAddrW-1:0];
          end
          if (func_q == FuncXfer) begin
            res_d.seg_length = chunk[SegLenW-1:0];
            rem_d = rem_q - chunk;
            cur_off_d = cur_off_q + SizeW'(chunk);
            if (rem_d != '0) begin
              res_d.last_segment = 1'b0;
              state_d = streaming ? S_SCAN : S_EMIT;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (state_q == S_IDLE && start) begin
      cur_off_d = SizeW'(req_i.byte_offset);
      rem_d = (req_i.xfer_length > XferCap) ? XferCap : req_i.xfer_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q <= '0;
      rom_size_q <= '0;
      pic_q <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      pic_q <= pic_d;
      res_v_q <= (state_q == S_EMIT);
      if (cfg_we_i) begin
        rom_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      func_q <= req_i.func;
    end
    cur_off_q <= cur_off_d;
    rem_q <= rem_d;
    nf_q <= nf_d;
    hit_q <= hit_d;
    hit_idx_q <= hit_idx_d;
    hit_rank_q <= hit_rank_d;
    vic_idx_q <= vic_idx_d;
    vic_rank_q <= vic_rank_d;
    vic_blk_q <= vic_blk_d;
    tgt_q <= tgt_d;
    tgt_rank_q <= tgt_rank_d;
    miss_q <= miss_d;
    res_q <= res_d;
  end

  // frame table RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign result_valid_o = res_v_q;
  assign result_o = res_q;

  a_paged_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.paged_in |-> result_o.found)
    else $error("page-in reported on a word without a valid address");

  a_count_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> result_o.page_in_total == pic_q)
    else $error("page-in total out of step with counter");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_CLEAR || state_q == S_UPD))
    else $error("frame table written outside fill or update");

endmodule

/* sim/tb_rom_block_window_lru.sv */
// Testbench for rom_block_window_lru: drives lookups and transfers, predicts every
// segment word with a local LRU frame table. Depends on rbw_pkg and the block RTL.
`timescale 1ns / 100ps

module tb_rom_block_window_lru;
  import rbw_pkg::*;

  localparam int unsigned BlkBytes = 65536;
  localparam int unsigned MaxBlks  = 1024;
  localparam int unsigned Frames   = 16;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [SizeW-1:0]    cfg_wdata_i;
  logic                start;
  logic                busy;
  req_t                req_i;
  logic                result_valid_o;
  rsp_t                result_o;

  rom_block_window_lru uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // predictor state
  logic [SizeW-1:0]  rom_bytes;
  logic [9:0]        frame_blk [Frames];
  int unsigned       frame_rank[Frames];
  logic [CountW-1:0] page_ins;

  req_t pending_reqs[$];
  rsp_t expected_segs[$];
  int   errors;
  int   send_idle_pct;
  // sampled at the rising edge so the driver knows whether its word went in
  logic busy_at_edge;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic void bump_frame(int f);
    int unsigned r;
    r = frame_rank[f];
    for (int i = 0; i < Frames; i++) begin
      if (frame_rank[i] < r) frame_rank[i]++;
    end
    frame_rank[f] = 0;
  endfunction

  // returns the frame holding blk; on a miss evicts the oldest frame
  function automatic int find_frame(longint unsigned blk, output bit paged,
                                    output logic [9:0] ev);
    int victim;
    victim = 0;
    paged  = 1'b0;
    ev     = '0;
    for (int i = 0; i < Frames; i++) begin
      if (longint'(frame_blk[i]) == blk) return i;
    end
    for (int i = 1; i < Frames; i++) begin
      if (frame_rank[i] > frame_rank[victim]) victim = i;
    end
    ev = frame_blk[victim];
    frame_blk[victim] = blk[9:0];
    page_ins++;
    bump_frame(victim);
    paged = 1'b1;
    return victim;
  endfunction

  function automatic void push_seg(longint unsigned addr, longint unsigned len, bit fnd,
                                   bit paged, logic [9:0] ev, bit last);
    rsp_t s;
    s.window_addr   = addr[WAddrW-1:0];
    s.seg_length    = len[SegLenW-1:0];
    s.found         = fnd;
    s.paged_in      = paged;
    s.evicted_block = paged ? ev : '0;
    s.page_in_total = page_ins;
    s.last_segment  = last;
    expected_segs.push_back(s);
  endfunction

  function automatic void predict_segments(req_t r);
    longint unsigned eff, off, len, inb, chunk, addr;
    bit              stream, paged;
    logic [9:0]      ev;
    int              f;
    eff = rom_bytes;
    if (eff > longint'(MaxBlks) * BlkBytes) eff = longint'(MaxBlks) * BlkBytes;
    stream = eff > longint'(Frames) * BlkBytes;
    off = r.byte_offset;
    len = r.xfer_length;
    paged = 1'b0;
    ev = '0;
    if (len > 1048576) len = 1048576;
    if (eff == 0) begin
      push_seg(0, 0, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    if (r.func == FuncLookup) begin
      if (off >= eff) off = eff - 1;
      if (stream) begin
        f = find_frame(off / BlkBytes, paged, ev);
        addr = longint'(f) * BlkBytes + off % BlkBytes;
      end else begin
        addr = off;
      end
      push_seg(addr, 0, 1'b1, paged, ev, 1'b1);
      return;
    end
    if (off >= eff) len = 0;
    else if (off + len > eff) len = eff - off;
    if (len == 0) begin
      push_seg(0, 0, 1'b0, 1'b0, '0, 1'b1);
      return;
    end
    while (len != 0) begin
      inb = off % BlkBytes;
      chunk = BlkBytes - inb;
      if (chunk > len) chunk = len;
      if (stream) begin
        f = find_frame(off / BlkBytes, paged, ev);
        bump_frame(f);
        addr = longint'(f) * BlkBytes + inb;
      end else begin
        paged = 1'b0;
        ev = '0;
        addr = off;
      end
      len -= chunk;
      push_seg(addr, chunk, 1'b1, paged, ev, len == 0);
      off += chunk;
    end
  endfunction

  // driver: start stays up while words are queued and no idle is drawn
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy_at_edge) begin
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        start <= 1'b1;
        req_i <= pending_reqs[0];
      end else begin
        start <= 1'b0;
        req_i <= req_t'($urandom());
      end
    end
  end

  always @(posedge clk_i) begin
    busy_at_edge <= busy;
    if (rst_ni && start && !busy) predict_segments(req_i);
  end

  // monitor
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_segs.size() == 0) begin
        $error("unexpected segment word %p", result_o);
        errors++;
      end else begin
        e = expected_segs.pop_front();
        if (result_o.window_addr !== e.window_addr) begin
          $error("window_addr exp %0h got %0h", e.window_addr, result_o.window_addr);
          errors++;
        end
        if (result_o.seg_length !== e.seg_length) begin
          $error("seg_length exp %0h got %0h", e.seg_length, result_o.seg_length);
          errors++;
        end
        if (result_o.found !== e.found) begin
          $error("found exp %0b got %0b", e.found, result_o.found);
          errors++;
        end
        if (result_o.paged_in !== e.paged_in) begin
          $error("paged_in exp %0b got %0b", e.paged_in, result_o.paged_in);
          errors++;
        end
        if (result_o.evicted_block !== e.evicted_block) begin
          $error("evicted_block exp %0d got %0d", e.evicted_block, result_o.evicted_block);
          errors++;
        end
        if (result_o.page_in_total !== e.page_in_total) begin
          $error("page_in_total exp %0d got %0d", e.page_in_total, result_o.page_in_total);
          errors++;
        end
        if (result_o.last_segment !== e.last_segment) begin
          $error("last_segment exp %0b got %0b", e.last_segment, result_o.last_segment);
          errors++;
        end
      end
    end
  end

  function automatic req_t mk_req(bit fn, longint unsigned off, longint unsigned len);
    req_t r;
    r.func        = fn;
    r.byte_offset = off[OffW-1:0];
    r.xfer_length = len[XLenW-1:0];
    return r;
  endfunction

  // random word aimed at the current ROM size; mostly short accesses, some near or past the ROM end
  function automatic req_t rand_req();
    longint unsigned off, len, span;
    span = (rom_bytes == 0) ? 64'd1 << 21 : rom_bytes;
    case ($urandom_range(9))
      0: off = $urandom_range(2 ** OffW - 1);
      1: off = span + $urandom_range(1000);
      2: off = span - 1 - $urandom_range(300);
      default: off = $urandom_range(span > 0 ? span - 1 : 0);
    endcase
    case ($urandom_range(9))
      0: len = $urandom_range(2 ** XLenW - 1);
      1: len = 1048576;
      2: len = 0;
      3, 4: len = $urandom_range(200000);
      default: len = $urandom_range(4096);
    endcase
    return mk_req($urandom_range(1), off, len);
  endfunction

  task automatic drain();
    wait (pending_reqs.size() == 0);
    @(negedge clk_i);
    @(negedge clk_i);
    while (expected_segs.size() != 0 || busy) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  task automatic set_rom_size(logic [SizeW-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    rom_bytes   = v;
  endtask

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(rand_req());
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    start         = 1'b0;
    req_i         = '0;
    busy_at_edge  = 1'b1;
    errors        = 0;
    send_idle_pct = 27;
    rom_bytes     = '0;
    page_ins      = '0;
    for (int i = 0; i < Frames; i++) begin
      frame_blk[i]  = 10'(i);
      frame_rank[i] = i;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);
    while (busy) @(negedge clk_i);

    // zero-size ROM, then a few directed cases in streaming mode
    pending_reqs.push_back(mk_req(FuncLookup, 5, 0));
    pending_reqs.push_back(mk_req(FuncXfer, 0, 100));
    drain();
    set_rom_size(27'd4 * 1024 * 1024);
    pending_reqs.push_back(mk_req(FuncLookup, 0, 0));
    pending_reqs.push_back(mk_req(FuncLookup, 20 * BlkBytes + 7, 0));
    pending_reqs.push_back(mk_req(FuncLookup, 20 * BlkBytes + 9, 0));
    pending_reqs.push_back(mk_req(FuncLookup, 2 ** OffW - 1, 0));
    pending_reqs.push_back(mk_req(FuncXfer, BlkBytes - 10, 20));
    pending_reqs.push_back(mk_req(FuncXfer, 100, 2 ** XLenW - 1));
    pending_reqs.push_back(mk_req(FuncXfer, 30 * BlkBytes + 5, 1048576));
    pending_reqs.push_back(mk_req(FuncXfer, 4 * 1024 * 1024 - 8, 100));
    pending_reqs.push_back(mk_req(FuncXfer, 4 * 1024 * 1024, 100));
    pending_reqs.push_back(mk_req(FuncXfer, 123, 0));
    pending_reqs.push_back(mk_req(FuncXfer, 45 * BlkBytes, BlkBytes));
    drain();
    // non-streaming: ROM fits in the window
    set_rom_size(27'd1000000);
    pending_reqs.push_back(mk_req(FuncLookup, 2000000, 0));
    pending_reqs.push_back(mk_req(FuncXfer, 999000, 5000));
    pending_reqs.push_back(mk_req(FuncXfer, 3, 200000));
    drain();

    run_random(60);
    // above the block cap, clamped to 64 MiB
    set_rom_size(27'h7FF_FFFF);
    run_random(60);
    send_idle_pct = 59;
    set_rom_size(27'd16 * BlkBytes + 1);
    run_random(60);
    set_rom_size(27'd1);
    run_random(30);
    send_idle_pct = 0;
    set_rom_size(27'd16 * BlkBytes);
    run_random(40);
    set_rom_size(27'd1300000);
    run_random(70);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #400ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
